### sv/bbt_pkg.sv
package bbt_pkg;

    localparam int unsigned FRAME_WIDTH  = 208;
    localparam int unsigned FRAME_HEIGHT = 156;
    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [14:0] WEIGHT_RED   = 15'd19595;
    localparam logic [15:0] WEIGHT_GREEN = 16'd38469;
    localparam logic [12:0] WEIGHT_BLUE  = 13'd7472;

    localparam logic [7:0] BOX_MIN_INIT  = 8'd210;
    localparam logic [7:0] NEAR_ROW_HIGH = 8'd144;
    localparam logic [7:0] NEAR_ROW_LOW  = 8'd15;
    localparam logic [7:0] NEAR_COL_HIGH = 8'd187;
    localparam logic [7:0] NEAR_COL_LOW  = 8'd70;

    localparam logic [5:0] THRESHOLD_RESET = 6'd23;
    localparam logic [7:0] ROW_LOW_RESET   = 8'd10;
    localparam logic [7:0] ROW_HIGH_RESET  = 8'd149;
    localparam logic [7:0] COL_LOW_RESET   = 8'd64;
    localparam logic [7:0] COL_HIGH_RESET  = 8'd192;

    typedef enum logic [2:0] {
        REG_GRAY_THRESHOLD  = 3'd0,
        REG_WINDOW_ROW_LOW  = 3'd1,
        REG_WINDOW_ROW_HIGH = 3'd2,
        REG_WINDOW_COL_LOW  = 3'd3,
        REG_WINDOW_COL_HIGH = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [5:0] gray_threshold;
        logic [7:0] window_row_low;
        logic [7:0] window_row_high;
        logic [7:0] window_col_low;
        logic [7:0] window_col_high;
    } cfg_t;

    // one classified pixel on its way to the box tracker
    typedef struct packed {
        logic       bright;
        logic       track;
        logic       eof;
        logic [7:0] row;
        logic [7:0] col;
    } qentry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } qctl_t;

    typedef struct packed {
        logic full;
        logic valid;
    } qstat_t;

    typedef struct packed {
        logic       bright_mask;
        logic       frame_done;
        logic [7:0] center_row;
        logic [7:0] center_col;
        logic [7:0] box_row_max;
        logic [7:0] box_row_min;
        logic [7:0] box_col_max;
        logic [7:0] box_col_min;
        logic       near_row_high;
        logic       near_row_low;
        logic       near_col_high;
        logic       near_col_low;
    } result_t;

endpackage

### sv/bbt_pixel_if.sv
interface bbt_pixel_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_rgb565;
    logic        end_of_frame;

    modport source (output valid, output pixel_rgb565, output end_of_frame, input ready);
    modport sink (input valid, input pixel_rgb565, input end_of_frame, output ready);
endinterface

### sv/bbt_result_if.sv
interface bbt_result_if;
    logic       valid;
    logic       ready;
    logic       bright_mask;
    logic       frame_done;
    logic [7:0] center_row;
    logic [7:0] center_col;
    logic [7:0] box_row_max;
    logic [7:0] box_row_min;
    logic [7:0] box_col_max;
    logic [7:0] box_col_min;
    logic       near_row_high;
    logic       near_row_low;
    logic       near_col_high;
    logic       near_col_low;

    modport source (
        output valid, output bright_mask, output frame_done,
        output center_row, output center_col,
        output box_row_max, output box_row_min, output box_col_max, output box_col_min,
        output near_row_high, output near_row_low, output near_col_high, output near_col_low,
        input ready
    );
    modport sink (
        input valid, input bright_mask, input frame_done,
        input center_row, input center_col,
        input box_row_max, input box_row_min, input box_col_max, input box_col_min,
        input near_row_high, input near_row_low, input near_col_high, input near_col_low,
        output ready
    );
endinterface

### sv/bright_blob_box_tracker.sv
// Bright blob bounding-box tracker.
// pix carries RGB565 pixels in raster order with end_of_frame on the last pixel
// of each frame; res returns one result per pixel: its bright mask bit and, on
// the last pixel, the frame summary (box, midpoint centre, near-edge flags).
// Registers are written through cfg_we / cfg_index / cfg_data, one per cycle;
// the user must write them only while the block is idle; the block itself does
// not enforce it. A taken pixel is written into the queue, then popped into the
// output register that drives res. Throughput: one pixel per clock while the
// queue is not full; gray multiply-add, compare and box update are combinational.
// A four-entry queue between classifier and box tracker, plus the output
// register, absorb stalls: while res.ready is low, pix keeps being taken until
// the queue is full, then pix.ready drops.
// Reset returns the registers to their defaults, the position to row 0
// column 0 and the box to max 0 / min 210; the queue and output come up empty.
module bright_blob_box_tracker (
    input  logic        clk,
    input  logic        rst_n,
    bbt_pixel_if.sink   pix,
    bbt_result_if.source res,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    bbt_pkg::cfg_t    cfg_reg;
    bbt_pkg::qctl_t   qctl;
    bbt_pkg::qstat_t  qstat;
    bbt_pkg::qentry_t front_entry;
    bbt_pkg::qentry_t head_entry;
    logic             push;
    logic             pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gray_threshold  <= bbt_pkg::THRESHOLD_RESET;
            cfg_reg.window_row_low  <= bbt_pkg::ROW_LOW_RESET;
            cfg_reg.window_row_high <= bbt_pkg::ROW_HIGH_RESET;
            cfg_reg.window_col_low  <= bbt_pkg::COL_LOW_RESET;
            cfg_reg.window_col_high <= bbt_pkg::COL_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            case (bbt_pkg::cfg_index_t'(cfg_index))
                bbt_pkg::REG_GRAY_THRESHOLD:  cfg_reg.gray_threshold  <= cfg_data[5:0];
                bbt_pkg::REG_WINDOW_ROW_LOW:  cfg_reg.window_row_low  <= cfg_data;
                bbt_pkg::REG_WINDOW_ROW_HIGH: cfg_reg.window_row_high <= cfg_data;
                bbt_pkg::REG_WINDOW_COL_LOW:  cfg_reg.window_col_low  <= cfg_data;
                bbt_pkg::REG_WINDOW_COL_HIGH: cfg_reg.window_col_high <= cfg_data;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    assign qctl.push = push;
    assign qctl.pop  = pop;

    bbt_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .cfg   (cfg_reg),
        .qstat (qstat),
        .push  (push),
        .entry (front_entry)
    );

    bbt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (qctl),
        .wr_entry (front_entry),
        .stat     (qstat),
        .rd_entry (head_entry)
    );

    bbt_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .qstat (qstat),
        .head  (head_entry),
        .pop   (pop),
        .res   (res)
    );

endmodule

### sv/bbt_front.sv
module bbt_front (
    input  logic               clk,
    input  logic               rst_n,
    bbt_pixel_if.sink          pix,
    input  bbt_pkg::cfg_t      cfg,
    input  bbt_pkg::qstat_t    qstat,
    output logic               push,
    output bbt_pkg::qentry_t   entry
);

    logic [7:0]  row_reg, row_next;
    logic [7:0]  col_reg, col_next;
    logic [4:0]  red, blue;
    logic [5:0]  green;
    logic [21:0] weighted_sum;
    logic [5:0]  gray;
    logic        in_window;
    logic [8:0]  col_inc, row_inc;

    assign pix.ready = !qstat.full;
    assign push      = pix.valid && pix.ready;

    assign red   = pix.pixel_rgb565[15:11];
    assign green = pix.pixel_rgb565[10:5];
    assign blue  = pix.pixel_rgb565[4:0];

    // max sum stays below 2^22
    assign weighted_sum = 22'(red) * 22'(bbt_pkg::WEIGHT_RED)
                        + 22'(green) * 22'(bbt_pkg::WEIGHT_GREEN)
                        + 22'(blue) * 22'(bbt_pkg::WEIGHT_BLUE);
    assign gray = weighted_sum[21:16];

    assign in_window = (row_reg > cfg.window_row_low) && (row_reg < cfg.window_row_high)
                    && (col_reg > cfg.window_col_low) && (col_reg < cfg.window_col_high);

    always_comb
    begin
        entry.bright = (gray >= cfg.gray_threshold);
        entry.track  = entry.bright && in_window;
        entry.eof    = pix.end_of_frame;
        entry.row    = row_reg;
        entry.col    = col_reg;
    end

    assign col_inc = {1'b0, col_reg} + 9'd1;
    assign row_inc = {1'b0, row_reg} + 9'd1;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (push)
        begin
            if (pix.end_of_frame)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (col_inc >= 9'(bbt_pkg::FRAME_WIDTH))
            begin
                col_next = '0;
                row_next = (row_inc >= 9'(bbt_pkg::FRAME_HEIGHT)) ? 8'd0 : row_inc[7:0];
            end
            else
            begin
                col_next = col_inc[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

### sv/bbt_queue.sv
module bbt_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  bbt_pkg::qctl_t     ctl,
    input  bbt_pkg::qentry_t   wr_entry,
    output bbt_pkg::qstat_t    stat,
    output bbt_pkg::qentry_t   rd_entry
);

    localparam int unsigned PW = bbt_pkg::QPTR_W;

    bbt_pkg::qentry_t slot_reg [bbt_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]      count_reg, count_next;

    assign stat.full  = (count_reg == (PW+1)'(bbt_pkg::QUEUE_DEPTH));
    assign stat.valid = (count_reg != '0);
    assign rd_entry   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({ctl.push, ctl.pop})
            2'b10:   count_next = count_reg + (PW+1)'(1);
            2'b01:   count_next = count_reg - (PW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (ctl.push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (ctl.pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

### sv/bbt_back.sv
module bbt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  bbt_pkg::qstat_t    qstat,
    input  bbt_pkg::qentry_t   head,
    output logic               pop,
    bbt_result_if.source       res
);

    logic [7:0] rmax_reg, rmin_reg, cmax_reg, cmin_reg;
    logic [7:0] rmax_next, rmin_next, cmax_next, cmin_next;
    logic [8:0] row_sum, col_sum;
    logic       out_valid_reg;
    bbt_pkg::result_t res_reg, res_next;

    assign pop = qstat.valid && (!out_valid_reg || res.ready);

    // widen the box first: the last pixel of a frame counts towards its own report
    always_comb
    begin
        rmax_next = (head.track && head.row > rmax_reg) ? head.row : rmax_reg;
        rmin_next = (head.track && head.row < rmin_reg) ? head.row : rmin_reg;
        cmax_next = (head.track && head.col > cmax_reg) ? head.col : cmax_reg;
        cmin_next = (head.track && head.col < cmin_reg) ? head.col : cmin_reg;
    end

    assign row_sum = {1'b0, rmax_next} + {1'b0, rmin_next};
    assign col_sum = {1'b0, cmax_next} + {1'b0, cmin_next};

    always_comb
    begin
        res_next             = '0;
        res_next.bright_mask = head.bright;
        if (head.eof)
        begin
            res_next.frame_done    = 1'b1;
            res_next.center_row    = row_sum[8:1];
            res_next.center_col    = col_sum[8:1];
            res_next.box_row_max   = rmax_next;
            res_next.box_row_min   = rmin_next;
            res_next.box_col_max   = cmax_next;
            res_next.box_col_min   = cmin_next;
            res_next.near_row_high = (rmax_next > bbt_pkg::NEAR_ROW_HIGH);
            res_next.near_row_low  = (rmin_next < bbt_pkg::NEAR_ROW_LOW);
            res_next.near_col_high = (cmax_next > bbt_pkg::NEAR_COL_HIGH);
            res_next.near_col_low  = (cmin_next < bbt_pkg::NEAR_COL_LOW);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rmax_reg      <= '0;
            rmin_reg      <= bbt_pkg::BOX_MIN_INIT;
            cmax_reg      <= '0;
            cmin_reg      <= bbt_pkg::BOX_MIN_INIT;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
            if (head.eof)
            begin
                rmax_reg <= '0;
                rmin_reg <= bbt_pkg::BOX_MIN_INIT;
                cmax_reg <= '0;
                cmin_reg <= bbt_pkg::BOX_MIN_INIT;
            end
            else
            begin
                rmax_reg <= rmax_next;
                rmin_reg <= rmin_next;
                cmax_reg <= cmax_next;
                cmin_reg <= cmin_next;
            end
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            res_reg <= res_next;
    end

    assign res.valid         = out_valid_reg;
    assign res.bright_mask   = res_reg.bright_mask;
    assign res.frame_done    = res_reg.frame_done;
    assign res.center_row    = res_reg.center_row;
    assign res.center_col    = res_reg.center_col;
    assign res.box_row_max   = res_reg.box_row_max;
    assign res.box_row_min   = res_reg.box_row_min;
    assign res.box_col_max   = res_reg.box_col_max;
    assign res.box_col_min   = res_reg.box_col_min;
    assign res.near_row_high = res_reg.near_row_high;
    assign res.near_row_low  = res_reg.near_row_low;
    assign res.near_col_high = res_reg.near_col_high;
    assign res.near_col_low  = res_reg.near_col_low;

endmodule
